@@ rtl/sud_pkg.sv @@
// Package for the 64-bit signed/unsigned divider.
// Holds the data width, pipeline latency, command codes and the control struct
// passed along the chain of division cells. No dependencies.
package sud_pkg;

    localparam int DATA_WIDTH = 64;
    // One prepare stage, one cell per quotient bit, one result stage.
    localparam int LATENCY    = DATA_WIDTH + 2;

    typedef enum logic [1:0] {
        CMD_UDIV = 2'd0,
        CMD_UREM = 2'd1,
        CMD_SDIV = 2'd2,
        CMD_SREM = 2'd3
    } t_cmd;

    // Control that travels alongside each word through the cell chain.
    typedef struct packed {
        logic valid;
        logic want_rem;
        logic neg_q;
        logic neg_r;
    } t_ctrl;

endpackage

@@ rtl/sud_cell.sv @@
// One restoring-division cell: resolves a single quotient bit per word.
// Depends on sud_pkg for the data width and the control struct.
module sud_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sud_pkg::t_ctrl                     i_ctrl,
    input  logic [sud_pkg::DATA_WIDTH-1:0]     i_den,
    input  logic [sud_pkg::DATA_WIDTH-1:0]     i_rem,
    input  logic [sud_pkg::DATA_WIDTH-1:0]     i_nq,
    output sud_pkg::t_ctrl                     o_ctrl,
    output logic [sud_pkg::DATA_WIDTH-1:0]     o_den,
    output logic [sud_pkg::DATA_WIDTH-1:0]     o_rem,
    output logic [sud_pkg::DATA_WIDTH-1:0]     o_nq
);

    localparam int W = sud_pkg::DATA_WIDTH;

    sud_pkg::t_ctrl r_ctrl;
    logic [W-1:0]   r_den;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_nq;

    logic [W-1:0]   n_rem;
    logic [W-1:0]   n_nq;
    logic [W-1:0]   rem_sh;
    logic [W:0]     diff;
    logic           ge;

    // The partial remainder keeps its shifted-out top bit as a carry, so the
    // comparison against the divisor is done on W+1 bits.
    always_comb begin
        rem_sh = {i_rem[W-2:0], i_nq[W-1]};
        diff   = {i_rem[W-1], rem_sh} - {1'b0, i_den};
        ge     = ~diff[W];
        n_rem  = ge ? diff[W-1:0] : rem_sh;
        // Dividend bits leave at the top while quotient bits enter at the bottom.
        n_nq   = {i_nq[W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= i_den;
        r_rem <= n_rem;
        r_nq  <= n_nq;
    end

    assign o_ctrl = r_ctrl;
    assign o_den  = r_den;
    assign o_rem  = r_rem;
    assign o_nq   = r_nq;

endmodule

@@ rtl/signed_unsigned_divider_64.sv @@
// Top level of the pipelined 64-bit signed/unsigned divider.
// Depends on sud_pkg and sud_cell.
//
// Usage:
//   A word is taken at each rising edge where start is high and busy is low.
//   i_cmd selects unsigned quotient, unsigned remainder, signed quotient or
//   signed remainder; i_dividend and i_divisor carry the operands.
//   busy is high only while reset is held; otherwise the block takes a new
//   word in every cycle.
//   The result is on o_result for exactly one cycle with o_done high, and
//   results come out in the order in which their words were taken.
//   The latency is set by the chain of 64 division cells, one per quotient
//   bit, plus a stage that forms the operand magnitudes and a stage that
//   restores the result sign. Throughput is one word per cycle.
//   Signed commands divide magnitudes, negate the quotient when the signs
//   differ and give the remainder the sign of the dividend. A zero divisor
//   gives an all-ones quotient magnitude and the dividend as remainder.
//   A synchronous reset empties the pipeline; words in flight are dropped.
//   The receiver cannot hold results off and none is needed.
module signed_unsigned_divider_64 (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_cmd,
    input  logic [sud_pkg::DATA_WIDTH-1:0]     i_dividend,
    input  logic [sud_pkg::DATA_WIDTH-1:0]     i_divisor,
    output logic                               o_done,
    output logic [sud_pkg::DATA_WIDTH-1:0]     o_result
);

    localparam int W = sud_pkg::DATA_WIDTH;

    sud_pkg::t_ctrl c_ctrl [0:W];
    logic [W-1:0]   c_den  [0:W];
    logic [W-1:0]   c_rem  [0:W];
    logic [W-1:0]   c_nq   [0:W];

    sud_pkg::t_ctrl n_ctrl;
    logic [W-1:0]   n_a_mag;
    logic [W-1:0]   n_b_mag;
    logic           is_signed;
    logic           a_neg;
    logic           b_neg;

    sud_pkg::t_ctrl r_ctrl;
    logic [W-1:0]   r_a_mag;
    logic [W-1:0]   r_b_mag;

    logic           r_done;
    logic [W-1:0]   r_result;
    logic [W-1:0]   n_result;
    sud_pkg::t_ctrl last_ctrl;

    // Words are refused while reset is held.
    assign busy = ~i_rst_n;

    // Prepare stage: operand magnitudes and the sign fix-ups for the end.
    always_comb begin
        is_signed       = (i_cmd == sud_pkg::CMD_SDIV) || (i_cmd == sud_pkg::CMD_SREM);
        a_neg           = is_signed & i_dividend[W-1];
        b_neg           = is_signed & i_divisor[W-1];
        n_a_mag         = a_neg ? (~i_dividend + W'(1)) : i_dividend;
        n_b_mag         = b_neg ? (~i_divisor + W'(1)) : i_divisor;
        n_ctrl.valid    = start & ~busy;
        n_ctrl.want_rem = (i_cmd == sud_pkg::CMD_UREM) || (i_cmd == sud_pkg::CMD_SREM);
        n_ctrl.neg_q    = a_neg ^ b_neg;
        n_ctrl.neg_r    = a_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mag <= n_a_mag;
        r_b_mag <= n_b_mag;
    end

    assign c_ctrl[0] = r_ctrl;
    assign c_den[0]  = r_b_mag;
    assign c_rem[0]  = '0;
    assign c_nq[0]   = r_a_mag;

    for (genvar g = 0; g < W; g++) begin : g_cell
        sud_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (c_ctrl[g]),
            .i_den   (c_den[g]),
            .i_rem   (c_rem[g]),
            .i_nq    (c_nq[g]),
            .o_ctrl  (c_ctrl[g+1]),
            .o_den   (c_den[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_nq    (c_nq[g+1])
        );
    end

    // Result stage: pick quotient or remainder and restore its sign.
    always_comb begin
        last_ctrl = c_ctrl[W];
        if (last_ctrl.want_rem) begin
            n_result = last_ctrl.neg_r ? (~c_rem[W] + W'(1)) : c_rem[W];
        end else begin
            n_result = last_ctrl.neg_q ? (~c_nq[W] + W'(1)) : c_nq[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= last_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ rtl/sud_checker.sv @@
// Port-level checker for the divider, bound to the top level.
// Depends on sud_pkg for the latency and the command codes.
module sud_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [1:0]                         i_cmd,
    input  logic [sud_pkg::DATA_WIDTH-1:0]     i_dividend,
    input  logic [sud_pkg::DATA_WIDTH-1:0]     i_divisor,
    input  logic                               o_done,
    input  logic [sud_pkg::DATA_WIDTH-1:0]     o_result
);

    localparam int LAT = sud_pkg::LATENCY;
    localparam int CW  = $clog2(LAT + 2);

    logic [CW-1:0] r_since;
    logic          accept;
    logic          settled;

    // Counts cycles since reset so that words lost to a reset are not expected.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
        end else if (r_since <= CW'(LAT)) begin
            r_since <= r_since + CW'(1);
        end
    end

    assign accept  = start && !busy && i_rst_n;
    assign settled = (r_since > CW'(LAT));

    a_done_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LAT))
        else $error("result strobe without a word taken at the expected cycle");

    a_word_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (settled && $past(accept, LAT)) |-> o_done)
        else $error("word taken but no result after the pipeline latency");

    a_udiv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (settled && $past(accept && (i_cmd == sud_pkg::CMD_UDIV) && (i_divisor == '0), LAT))
        |-> (o_result == '1))
        else $error("unsigned division by zero did not give all ones");

    a_rem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (settled && $past(accept && ((i_cmd == sud_pkg::CMD_UREM) ||
                                     (i_cmd == sud_pkg::CMD_SREM)) &&
                          (i_divisor == '0), LAT))
        |-> (o_result == $past(i_dividend, LAT)))
        else $error("remainder by zero did not equal the dividend");

endmodule

bind signed_unsigned_divider_64 sud_checker u_sud_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_cmd      (i_cmd),
    .i_dividend (i_dividend),
    .i_divisor  (i_divisor),
    .o_done     (o_done),
    .o_result   (o_result)
);
